@@ sv/cst_pkg.sv @@
// Package of the C source token scanner: word types, codes and the reserved-word table.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

    localparam int DEF_MAX_LINE       = 256;
    localparam int DEF_KEYWORD_PREFIX = 8;
    localparam int DEF_LINE_BITS      = 16;

    // Token classes.
    localparam logic [3:0] CLS_PREP    = 4'd0;
    localparam logic [3:0] CLS_SPECIAL = 4'd1;
    localparam logic [3:0] CLS_OPER    = 4'd2;
    localparam logic [3:0] CLS_CHAR    = 4'd3;
    localparam logic [3:0] CLS_STRING  = 4'd4;
    localparam logic [3:0] CLS_LCOM    = 4'd5;
    localparam logic [3:0] CLS_BCOM    = 4'd6;
    localparam logic [3:0] CLS_IDEN    = 4'd7;
    localparam logic [3:0] CLS_RESVD   = 4'd8;
    localparam logic [3:0] CLS_INT     = 4'd9;
    localparam logic [3:0] CLS_FLOAT   = 4'd10;
    localparam logic [3:0] CLS_ERR_CHR = 4'd11;
    localparam logic [3:0] CLS_ERR_STR = 4'd12;
    localparam logic [3:0] CLS_ERR_COM = 4'd13;

    localparam logic [4:0] NO_WORD   = 5'd25;
    localparam int         NUM_WORDS = 24;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  token_class;
        logic [15:0] start_line;
        logic [15:0] end_line;
        logic [7:0]  start_column;
        logic [7:0]  token_length;
        logic [4:0]  keyword_number;
        logic        last_in_run;
    } t_out_word;

    // Reserved word i, left aligned in eight bytes, first byte on top.
    function automatic logic [63:0] kw_text(input logic [4:0] i);
        logic [63:0] t;
        case (i)
            5'd0:  t = {"auto", 32'h0};
            5'd1:  t = {"break", 24'h0};
            5'd2:  t = {"case", 32'h0};
            5'd3:  t = "continue";
            5'd4:  t = {"char", 32'h0};
            5'd5:  t = {"const", 24'h0};
            5'd6:  t = {"do", 48'h0};
            5'd7:  t = {"default", 8'h0};
            5'd8:  t = {"double", 16'h0};
            5'd9:  t = {"else", 32'h0};
            5'd10: t = {"extern", 16'h0};
            5'd11: t = {"enum", 32'h0};
            5'd12: t = {"for", 40'h0};
            5'd13: t = {"float", 24'h0};
            5'd14: t = {"goto", 32'h0};
            5'd15: t = {"int", 40'h0};
            5'd16: t = {"if", 48'h0};
            5'd17: t = {"return", 16'h0};
            5'd18: t = "register";
            5'd19: t = {"static", 16'h0};
            5'd20: t = {"switch", 16'h0};
            5'd21: t = {"sizeof", 16'h0};
            5'd22: t = {"struct", 16'h0};
            5'd23: t = {"union", 24'h0};
            default: t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] i);
        logic [3:0] n;
        case (i)
            5'd6, 5'd16: n = 4'd2;
            5'd12, 5'd15: n = 4'd3;
            5'd0, 5'd2, 5'd4, 5'd9, 5'd11, 5'd14: n = 4'd4;
            5'd1, 5'd5, 5'd13, 5'd23: n = 4'd5;
            5'd8, 5'd10, 5'd17, 5'd19, 5'd20, 5'd21, 5'd22: n = 4'd6;
            5'd7: n = 4'd7;
            5'd3, 5'd18: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Parallel compare of the held word prefix against all reserved words.
    function automatic logic [4:0] kw_lookup(input logic [63:0] pfx, input logic [7:0] len);
        logic [63:0] mask;
        logic [4:0]  hit;
        hit  = NO_WORD;
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {len[3:0], 3'b000});
        if (len >= 8'd1 && len <= 8'd8) begin
            for (int i = NUM_WORDS - 1; i >= 0; i--) begin
                if ({4'd0, kw_len(5'(i))} == len && ((pfx ^ kw_text(5'(i))) & mask) == 64'h0) begin
                    hit = 5'(i);
                end
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

@@ sv/c_source_token_scanner.sv @@
// Top level of the C source token scanner: byte scanner and result queue.
//
//  channel | valid      | stall       | word
//  input   | i_in_valid | o_in_stall  | i_in_word  (t_in_word)
//  output  | o_out_valid| i_out_stall | o_out_word (t_out_word)
//
// Each byte is scanned in the cycle it is accepted; its zero, one or two tokens
// are written to a four-entry result queue and appear from the next cycle on.
// A byte is taken in every cycle while the queue has room for two words.
// Unstalled, the queue gives one word per cycle, which sets the rate for two-token bytes.
// Reset is synchronous and active low; it empties the queue and restores line one.
`timescale 1ns / 1ps
`default_nettype none
module c_source_token_scanner
    import cst_pkg::*;
#(
    parameter int MAX_LINE       = DEF_MAX_LINE,
    parameter int KEYWORD_PREFIX = DEF_KEYWORD_PREFIX,
    parameter int LINE_BITS      = DEF_LINE_BITS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_word  o_out_word
);

    localparam int COL_LIMIT_I = (MAX_LINE - 1 < 255) ? MAX_LINE - 1 : 255;
    localparam logic [7:0] COL_LIMIT = 8'(COL_LIMIT_I);
    localparam logic [15:0] LINE_LIMIT =
        (LINE_BITS >= 16) ? 16'hFFFF : 16'((1 << LINE_BITS) - 1);
    localparam int PW = $clog2(KEYWORD_PREFIX);

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_OP    = 4'd1;
    localparam logic [3:0] M_SLASH = 4'd2;
    localparam logic [3:0] M_DOT   = 4'd3;
    localparam logic [3:0] M_WORD  = 4'd4;
    localparam logic [3:0] M_NUM   = 4'd5;
    localparam logic [3:0] M_PREP  = 4'd6;
    localparam logic [3:0] M_LCOM  = 4'd7;
    localparam logic [3:0] M_BCOM  = 4'd8;
    localparam logic [3:0] M_CHAR  = 4'd9;
    localparam logic [3:0] M_STR   = 4'd10;

    localparam logic [7:0] NL = 8'd10;

    // Scanner state.
    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_line, n_line;
    logic [7:0]  r_col, n_col;
    logic [7:0]  r_tsc, n_tsc;
    logic [15:0] r_tsl, n_tsl;
    logic [7:0]  r_tlc, n_tlc;
    logic [7:0]  r_held, n_held;
    logic        r_bslash, n_bslash;
    logic [2:0]  r_nphase, n_nphase;
    logic [7:0]  r_prefix [KEYWORD_PREFIX];

    // Result queue.
    t_out_word   r_q [4];
    logic [1:0]  r_rp, r_wp;
    logic [2:0]  r_count, n_count;

    logic        in_acc, out_acc;
    logic        pw_en;
    logic [PW-1:0] pw_idx;
    logic [7:0]  pw_dat;
    logic [1:0]  ne;
    t_out_word   w [2];
    logic [63:0] pfx;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic pairs(input logic [7:0] f, input logic [7:0] c);
        logic p;
        case (f)
            "+": p = c == "+" || c == "=";
            "-": p = c == "-" || c == "=" || c == ">";
            ">": p = c == ">" || c == "=";
            "<": p = c == "<" || c == "=";
            "&": p = c == "&";
            "|": p = c == "|";
            default: p = c == "=";
        endcase
        return p;
    endfunction

    // Number grammar step: bit 3 says the byte is taken, low bits the new phase.
    function automatic logic [3:0] num_step(input logic [2:0] ph, input logic [7:0] c);
        logic [3:0] r;
        logic       e;
        e = c == "e" || c == "E";
        r = {1'b0, ph};
        case (ph)
            3'd0: begin
                if (is_digit(c)) r = {1'b1, ph};
                else if (c == ".") r = {1'b1, 3'd1};
                else if (e) r = {1'b1, 3'd2};
            end
            3'd1: begin
                if (is_digit(c)) r = {1'b1, ph};
                else if (e) r = {1'b1, 3'd2};
            end
            3'd2: begin
                if (c == "+" || c == "-") r = {1'b1, 3'd3};
                else if (is_digit(c)) r = {1'b1, 3'd4};
            end
            default: begin
                if (is_digit(c)) r = {1'b1, 3'd4};
            end
        endcase
        return r;
    endfunction

    function automatic t_out_word mk(input logic [3:0] cls, input logic [4:0] kw,
                                     input logic [15:0] sl, input logic [15:0] el,
                                     input logic [7:0] sc, input logic [7:0] tl);
        t_out_word o;
        o.token_class    = cls;
        o.start_line     = sl;
        o.end_line       = el;
        o.start_column   = sc;
        o.token_length   = tl;
        o.keyword_number = kw;
        o.last_in_run    = 1'b0;
        return o;
    endfunction

    // Handshakes.
    assign o_in_stall  = r_count > 3'd2;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_count != 3'd0;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_word  = r_q[r_rp];

    // The first eight prefix bytes, first byte on top, for the keyword compare.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            pfx[63 - 8 * k -: 8] = r_prefix[k];
        end
    end

    // Scan one byte: next state and up to two tokens.
    always_comb begin
        logic [7:0] c;
        logic       start;
        logic [3:0] ns;
        logic [4:0] kw;
        c        = i_in_word.char_byte;
        start    = 1'b0;
        ns       = 4'd0;
        kw       = NO_WORD;
        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_tsc    = r_tsc;
        n_tsl    = r_tsl;
        n_tlc    = r_tlc;
        n_held   = r_held;
        n_bslash = r_bslash;
        n_nphase = r_nphase;
        pw_en    = 1'b0;
        pw_idx   = '0;
        pw_dat   = c;
        ne       = 2'd0;
        w[0]     = mk(CLS_PREP, NO_WORD, 16'd0, 16'd0, 8'd0, 8'd0);
        w[1]     = w[0];
        kw       = kw_lookup(pfx, r_tlc);

        if (i_in_word.end_of_input) begin
            // Flush the open token, then return to the reset state.
            ne = 2'd1;
            case (r_mode)
                M_OP, M_SLASH, M_DOT:
                    w[0] = mk(CLS_OPER, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                M_WORD:
                    w[0] = mk((kw == NO_WORD) ? CLS_IDEN : CLS_RESVD, kw,
                              r_tsl, r_line, r_tsc, r_tlc);
                M_NUM:
                    w[0] = mk((r_nphase == 3'd0) ? CLS_INT : CLS_FLOAT, NO_WORD,
                              r_tsl, r_line, r_tsc, r_tlc);
                M_PREP:  w[0] = mk(CLS_PREP, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                M_LCOM:  w[0] = mk(CLS_LCOM, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                M_BCOM:  w[0] = mk(CLS_ERR_COM, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                M_CHAR:  w[0] = mk(CLS_ERR_CHR, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                M_STR:   w[0] = mk(CLS_ERR_STR, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                default: ne = 2'd0;
            endcase
            n_mode   = M_IDLE;
            n_line   = 16'd1;
            n_col    = 8'd0;
            n_tsc    = 8'd0;
            n_tsl    = 16'd1;
            n_tlc    = 8'd0;
            n_held   = 8'd0;
            n_bslash = 1'b0;
            n_nphase = 3'd0;
        end else begin
            // Continue or close the open token.
            case (r_mode)
                M_OP: begin
                    n_mode = M_IDLE;
                    if (pairs(r_held, c)) begin
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                    end else begin
                        start = 1'b1;
                    end
                    w[0] = mk(CLS_OPER, NO_WORD, r_tsl, r_line, r_tsc, n_tlc);
                    ne   = 2'd1;
                end
                M_SLASH: begin
                    if (c == "/") begin
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                        n_mode = M_LCOM;
                    end else if (c == "*") begin
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                        n_held   = 8'd0;
                        n_nphase = 3'd0;
                        n_mode   = M_BCOM;
                    end else begin
                        n_mode = M_IDLE;
                        if (c == "=") begin
                            if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                        end else begin
                            start = 1'b1;
                        end
                        w[0] = mk(CLS_OPER, NO_WORD, r_tsl, r_line, r_tsc, n_tlc);
                        ne   = 2'd1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                        n_nphase = 3'd1;
                        n_mode   = M_NUM;
                    end else begin
                        n_mode = M_IDLE;
                        w[0]   = mk(CLS_OPER, NO_WORD, r_tsl, r_line, r_tsc, r_tlc);
                        ne     = 2'd1;
                        start  = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (r_tlc < 8'(KEYWORD_PREFIX)) begin
                            pw_en  = 1'b1;
                            pw_idx = r_tlc[PW-1:0];
                        end
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                    end else begin
                        n_mode = M_IDLE;
                        w[0]   = mk((kw == NO_WORD) ? CLS_IDEN : CLS_RESVD, kw,
                                    r_tsl, r_line, r_tsc, r_tlc);
                        ne     = 2'd1;
                        start  = 1'b1;
                    end
                end
                M_NUM: begin
                    ns = num_step(r_nphase, c);
                    if (ns[3]) begin
                        n_nphase = ns[2:0];
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                    end else begin
                        n_mode = M_IDLE;
                        w[0]   = mk((r_nphase == 3'd0) ? CLS_INT : CLS_FLOAT, NO_WORD,
                                    r_tsl, r_line, r_tsc, r_tlc);
                        ne     = 2'd1;
                        start  = 1'b1;
                    end
                end
                M_PREP, M_LCOM: begin
                    if (c == NL) begin
                        w[0]   = mk((r_mode == M_PREP) ? CLS_PREP : CLS_LCOM, NO_WORD,
                                    r_tsl, r_line, r_tsc, r_tlc);
                        ne     = 2'd1;
                        n_mode = M_IDLE;
                    end else if (n_tlc != 8'hFF) begin
                        n_tlc = n_tlc + 8'd1;
                    end
                end
                M_BCOM: begin
                    if (c == NL) begin
                        n_nphase = 3'd1;
                        n_held   = NL;
                    end else begin
                        if (r_nphase == 3'd0 && n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                        if (c == "/" && r_held == "*") begin
                            w[0]   = mk(CLS_BCOM, NO_WORD, r_tsl, r_line, r_tsc, n_tlc);
                            ne     = 2'd1;
                            n_mode = M_IDLE;
                        end
                        n_held = c;
                    end
                end
                M_CHAR, M_STR: begin
                    if (c == NL) begin
                        w[0]   = mk((r_mode == M_CHAR) ? CLS_ERR_CHR : CLS_ERR_STR, NO_WORD,
                                    r_tsl, r_line, r_tsc, r_tlc);
                        ne     = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        if (n_tlc != 8'hFF) n_tlc = n_tlc + 8'd1;
                        if (r_bslash) begin
                            n_bslash = 1'b0;
                        end else if (c == "\\") begin
                            n_bslash = 1'b1;
                        end else if ((r_mode == M_CHAR && c == "'") ||
                                     (r_mode == M_STR && c == "\"")) begin
                            w[0]   = mk((r_mode == M_CHAR) ? CLS_CHAR : CLS_STRING, NO_WORD,
                                        r_tsl, r_line, r_tsc, n_tlc);
                            ne     = 2'd1;
                            n_mode = M_IDLE;
                        end
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    start  = 1'b1;
                end
            endcase

            // Start a new token from idle.
            if (start) begin
                case (c)
                    ";", "(", ")", "{", "}", ",", "[", "]", "^", ":": begin
                        n_tsl   = r_line;
                        n_tsc   = r_col;
                        n_tlc   = 8'd1;
                        w[ne[0]] = mk((c == ";" || c == "(" || c == ")" || c == "{" ||
                                       c == "}") ? CLS_SPECIAL : CLS_OPER, NO_WORD,
                                      r_line, r_line, r_col, 8'd1);
                        ne      = ne + 2'd1;
                    end
                    "+", "-", "*", "=", "%", ">", "<", "!", "&", "|": begin
                        n_tsl  = r_line;
                        n_tsc  = r_col;
                        n_tlc  = 8'd1;
                        n_held = c;
                        n_mode = M_OP;
                    end
                    "/", ".", "#": begin
                        n_tsl  = r_line;
                        n_tsc  = r_col;
                        n_tlc  = 8'd1;
                        n_mode = (c == "/") ? M_SLASH : ((c == ".") ? M_DOT : M_PREP);
                    end
                    "'", "\"": begin
                        n_tsl    = r_line;
                        n_tsc    = r_col;
                        n_tlc    = 8'd1;
                        n_bslash = 1'b0;
                        n_mode   = (c == "'") ? M_CHAR : M_STR;
                    end
                    default: begin
                        if (is_alpha(c)) begin
                            n_tsl  = r_line;
                            n_tsc  = r_col;
                            n_tlc  = 8'd1;
                            pw_en  = 1'b1;
                            pw_idx = '0;
                            n_mode = M_WORD;
                        end else if (is_digit(c)) begin
                            n_tsl    = r_line;
                            n_tsc    = r_col;
                            n_tlc    = 8'd1;
                            n_nphase = 3'd0;
                            n_mode   = M_NUM;
                        end
                    end
                endcase
            end

            // Position counters.
            if (c == NL) begin
                if (r_line < LINE_LIMIT) n_line = r_line + 16'd1;
                n_col = 8'd0;
            end else if (r_col < COL_LIMIT) begin
                n_col = r_col + 8'd1;
            end
        end

        // Mark the final word of this byte.
        if (ne == 2'd1) w[0].last_in_run = 1'b1;
        if (ne == 2'd2) w[1].last_in_run = 1'b1;
    end

    // Queue occupancy.
    always_comb begin
        n_count = r_count;
        if (in_acc) n_count = n_count + {1'b0, ne};
        if (out_acc) n_count = n_count - 3'd1;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_line   <= 16'd1;
            r_col    <= 8'd0;
            r_tsc    <= 8'd0;
            r_tsl    <= 16'd1;
            r_tlc    <= 8'd0;
            r_held   <= 8'd0;
            r_bslash <= 1'b0;
            r_nphase <= 3'd0;
            r_rp     <= 2'd0;
            r_wp     <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_mode   <= n_mode;
                r_line   <= n_line;
                r_col    <= n_col;
                r_tsc    <= n_tsc;
                r_tsl    <= n_tsl;
                r_tlc    <= n_tlc;
                r_held   <= n_held;
                r_bslash <= n_bslash;
                r_nphase <= n_nphase;
                r_wp     <= r_wp + ne;
            end
            if (out_acc) r_rp <= r_rp + 2'd1;
            r_count <= n_count;
        end
    end

    // Word prefix store and result queue storage.
    always_ff @(posedge i_clk) begin
        if (in_acc && pw_en) r_prefix[pw_idx] <= pw_dat;
        if (in_acc && ne != 2'd0) r_q[r_wp] <= w[0];
        if (in_acc && ne == 2'd2) r_q[r_wp + 2'd1] <= w[1];
    end

    // The queue never overfills.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // A byte is taken only with room for two words.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_count <= 3'd2)
        else $error("byte accepted without queue room");

    // End of input leaves the scanner idle on line one.
    a_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.end_of_input) |=> (r_mode == M_IDLE && r_line == 16'd1))
        else $error("end of input did not restore the scanner");

endmodule
`default_nettype wire
